// ===== hw/rtl/xor_then_aes128_ecb_pkcs7_encrypt_defines.svh =====
// Assertion macros shared by the RTL files of the XOR/AES encryptor.
// Used by modules that check their own sequencing.
`ifndef XOR_THEN_AES128_ECB_PKCS7_ENCRYPT_DEFINES_SVH
`define XOR_THEN_AES128_ECB_PKCS7_ENCRYPT_DEFINES_SVH
// Checks that an antecedent implies a consequent in the same cycle.
`define XAE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Checks that an antecedent implies a consequent in the next cycle.
`define XAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/xae_pkg.sv =====
// Package for the XOR/AES-128 encryptor: sizes, codes, S-box and round helpers.
// No dependencies.
`default_nettype none
package xae_pkg;
    localparam int BlockBytes = 16;
    localparam int XorKeyMax  = 16;

    typedef enum logic [2:0] {
        REG_XOR_KEY_LOW    = 3'd0,
        REG_XOR_KEY_HIGH   = 3'd1,
        REG_XOR_KEY_LENGTH = 3'd2,
        REG_AES_KEY_LOW    = 3'd3,
        REG_AES_KEY_HIGH   = 3'd4
    } reg_index_t;

    // Start request from the sequencer to the round engine.
    typedef struct packed {
        logic         start;
        logic [127:0] block;
        logic [127:0] key;
    } aes_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] block;
    } aes_rsp_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/xae_if.sv =====
// Valid/ready channel interfaces for the encryptor's input, output and config ports.
// Depends on nothing but the core language.
`default_nettype none
interface xae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] plain_byte;
    logic       carries_data;
    logic       message_end;
    modport source (output valid, plain_byte, carries_data, message_end, input ready);
    modport sink (input valid, plain_byte, carries_data, message_end, output ready);
endinterface

interface xae_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte;
    logic       final_byte;
    modport source (output valid, cipher_byte, final_byte, input ready);
    modport sink (input valid, cipher_byte, final_byte, output ready);
endinterface

interface xae_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/xae_round.sv =====
// Iterative AES-128 round engine: one round and one key-schedule step per cycle.
// Depends on xae_pkg and the assertion macro header.
`default_nettype none
`include "xor_then_aes128_ecb_pkcs7_encrypt_defines.svh"
module xae_round (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire xae_pkg::aes_req_t req,
    output xae_pkg::aes_rsp_t rsp
);
    logic [127:0] state_reg, key_reg;
    logic [7:0]   rcon_reg;
    logic [3:0]   round_reg;
    logic         busy_reg, done_reg;
    logic [127:0] key_next, sub, shf, mix, state_next;
    logic [7:0]   g0, g1, g2, g3;

    // Byte i of a 128-bit word sits at bits 8i upward.
    always_comb
    begin
        g0 = xae_pkg::SBOX[key_reg[13*8 +: 8]] ^ rcon_reg;
        g1 = xae_pkg::SBOX[key_reg[14*8 +: 8]];
        g2 = xae_pkg::SBOX[key_reg[15*8 +: 8]];
        g3 = xae_pkg::SBOX[key_reg[12*8 +: 8]];
        key_next[31:0] = key_reg[31:0] ^ {g3, g2, g1, g0};
        for (int w = 1; w < 4; w++)
        begin
            key_next[w*32 +: 32] = key_reg[w*32 +: 32] ^ key_next[(w-1)*32 +: 32];
        end
        for (int i = 0; i < 16; i++)
        begin
            sub[i*8 +: 8] = xae_pkg::SBOX[state_reg[i*8 +: 8]];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                shf[(i + 4*c)*8 +: 8] = sub[(i + 4*((c + i) % 4))*8 +: 8];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3;
            a0 = shf[(4*c)*8 +: 8];
            a1 = shf[(4*c+1)*8 +: 8];
            a2 = shf[(4*c+2)*8 +: 8];
            a3 = shf[(4*c+3)*8 +: 8];
            mix[(4*c)*8 +: 8]   = xae_pkg::xtime(a0) ^ xae_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
            mix[(4*c+1)*8 +: 8] = a0 ^ xae_pkg::xtime(a1) ^ xae_pkg::xtime(a2) ^ a2 ^ a3;
            mix[(4*c+2)*8 +: 8] = a0 ^ a1 ^ xae_pkg::xtime(a2) ^ xae_pkg::xtime(a3) ^ a3;
            mix[(4*c+3)*8 +: 8] = xae_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ xae_pkg::xtime(a3);
        end
        state_next = ((round_reg == 4'd10) ? shf : mix) ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= 4'd1;
            end
            else if (busy_reg)
            begin
                if (round_reg == 4'd10)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                round_reg <= round_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            state_reg <= req.block ^ req.key;
            key_reg   <= req.key;
            rcon_reg  <= 8'h01;
        end
        else if (busy_reg)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
            rcon_reg  <= xae_pkg::xtime(rcon_reg);
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.block = state_reg;

    `XAE_ASSERT_NEXT(a_done_after_last, clk, rst_n,
        busy_reg && round_reg == 4'd10 && !req.start, done_reg, "round engine missed done")
    `XAE_ASSERT_IMP(a_round_range, clk, rst_n,
        busy_reg, round_reg >= 4'd1 && round_reg <= 4'd10, "round count out of range")
    `XAE_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg, "done while busy")
endmodule
`default_nettype wire

// ===== hw/rtl/xor_then_aes128_ecb_pkcs7_encrypt.sv =====
// Top level: XOR pre-whitening, block collection, PKCS7 padding, output sequencing.
// Depends on xae_pkg, xae_if, xae_round and the assertion macro header.
//
//   channel | dir | payload
//   in      | in  | plain_byte[8], carries_data, message_end
//   out     | out | cipher_byte[8], final_byte
//   cfg     | in  | index[3], data[64]
//
// A data byte that completes no block is taken while idle. A block keeps the round engine
// busy for its ten rounds, then hands over the result, and then 16 output bytes
// follow. A final block that is not full first passes through the pad state; a full
// block that also ends the message is followed by a block of sixteens from that state.
// The input is not ready during encryption and output; output stalls simply hold.
// Reset clears the counters and loads key length 1 and zero keys.
`default_nettype none
`include "xor_then_aes128_ecb_pkcs7_encrypt_defines.svh"
module xor_then_aes128_ecb_pkcs7_encrypt (
    input wire logic  clk,
    input wire logic  rst_n,
    xae_in_if.sink    in,
    xae_out_if.source out,
    xae_cfg_if.sink   cfg
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_OUT  = 4'b0100,
        ST_PAD  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [63:0]   xkl_reg, xkh_reg, akl_reg, akh_reg;
    logic [4:0]    xlen_reg;
    logic [7:0]    buf_reg [16];
    logic [3:0]    fill_reg, xpos_reg, oidx_reg;
    logic          pend_end_reg, last_reg;
    logic [127:0]  cbuf_reg, blk;
    xae_pkg::aes_req_t req;
    xae_pkg::aes_rsp_t rsp;
    logic          in_acc, out_acc;
    logic [4:0]    len;
    logic [7:0]    kb;
    logic [4:0]    fill_end;
    logic [7:0]    pad_byte;

    xae_round u_round (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign in.ready  = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign in_acc    = in.valid && in.ready;
    assign out.valid = (state_reg == ST_OUT);
    assign out_acc   = out.valid && out.ready;
    assign out.cipher_byte = cbuf_reg[oidx_reg*8 +: 8];
    assign out.final_byte  = last_reg && (oidx_reg == 4'd15);

    always_comb
    begin
        len = (xlen_reg == 5'd0) ? 5'd1 : xlen_reg;
        if (len > 5'(xae_pkg::XorKeyMax)) len = 5'(xae_pkg::XorKeyMax);
        kb = xpos_reg[3] ? xkh_reg[xpos_reg[2:0]*8 +: 8] : xkl_reg[xpos_reg[2:0]*8 +: 8];
        // Bytes held once the incoming byte is stored, and the pad value for the tail.
        fill_end = {1'b0, fill_reg} + {4'd0, in.carries_data};
        pad_byte = 8'd16 - {3'd0, fill_end};
        for (int i = 0; i < xae_pkg::BlockBytes; i++)
        begin
            blk[i*8 +: 8] = buf_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xkl_reg  <= '0;
            xkh_reg  <= '0;
            akl_reg  <= '0;
            akh_reg  <= '0;
            xlen_reg <= 5'd1;
        end
        else if (cfg.valid)
        begin
            case (xae_pkg::reg_index_t'(cfg.index))
                xae_pkg::REG_XOR_KEY_LOW:    xkl_reg  <= cfg.data;
                xae_pkg::REG_XOR_KEY_HIGH:   xkh_reg  <= cfg.data;
                xae_pkg::REG_XOR_KEY_LENGTH: xlen_reg <= cfg.data[4:0];
                xae_pkg::REG_AES_KEY_LOW:    akl_reg  <= cfg.data;
                xae_pkg::REG_AES_KEY_HIGH:   akh_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req.start  = 1'b0;
        req.block  = blk;
        req.key    = {akh_reg, akl_reg};
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in.carries_data && fill_reg == 4'd15)
                begin
                    // Last byte goes straight into the request; buffer write lands late.
                    req.start = 1'b1;
                    req.block = {in.plain_byte ^ kb, blk[119:0]};
                    state_next = ST_RUN;
                end
                else if (in_acc && in.message_end)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // A full block that ended the message is followed by a block of sixteens.
                req.start  = 1'b1;
                req.block  = pend_end_reg ? {xae_pkg::BlockBytes{8'd16}} : blk;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (rsp.done) state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_acc && oidx_reg == 4'd15)
                    state_next = pend_end_reg ? ST_PAD : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= 4'd0;
            xpos_reg     <= 4'd0;
            oidx_reg     <= 4'd0;
            pend_end_reg <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                if (in.carries_data)
                begin
                    fill_reg <= fill_reg + 4'd1;
                end
                if (in.message_end)
                begin
                    xpos_reg <= 4'd0;
                end
                else if (in.carries_data)
                begin
                    xpos_reg <= ({1'b0, xpos_reg} + 5'd1 >= len) ? 4'd0 : xpos_reg + 4'd1;
                end
                pend_end_reg <= in.message_end && in.carries_data && fill_reg == 4'd15;
                last_reg     <= in.message_end && !(in.carries_data && fill_reg == 4'd15);
            end
            if (state_reg == ST_PAD)
            begin
                fill_reg     <= 4'd0;
                pend_end_reg <= 1'b0;
                last_reg     <= 1'b1;
            end
            if (out_acc)
            begin
                oidx_reg <= oidx_reg + 4'd1;
            end
        end
    end

    // Block buffer and cipher output register need no reset.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            // Store the new byte; at message end pad the unfilled tail with the pad length.
            for (int i = 0; i < xae_pkg::BlockBytes; i++)
            begin
                if (in.carries_data && 4'(i) == fill_reg)
                    buf_reg[i] <= in.plain_byte ^ kb;
                else if (in.message_end && 5'(i) >= fill_end)
                    buf_reg[i] <= pad_byte;
            end
        end
        if (rsp.done) cbuf_reg <= rsp.block;
    end

    `XAE_ASSERT_IMP(a_no_in_when_busy, clk, rst_n,
        state_reg != ST_IDLE, !in.ready, "input ready while busy")
    `XAE_ASSERT_NEXT(a_pad_starts, clk, rst_n,
        state_reg == ST_PAD, state_reg == ST_RUN, "pad did not start engine")
    `XAE_ASSERT_IMP(a_final_last_word, clk, rst_n,
        out.valid && out.final_byte, oidx_reg == 4'd15, "final flag off last word")
endmodule
`default_nettype wire
